// ----- hdl/hmsl_pkg.sv -----
`default_nettype none

package hmsl_pkg;

  localparam int MOTOR_COUNT = 4;

  // op codes of an input beat
  localparam logic [1:0] OP_SETTING = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_HIT     = 2'd2;

  // mode codes, bits 1:0 of the mode byte
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FAN  = 2'd1;
  localparam logic [1:0] MODE_COOL = 2'd2;
  localparam logic [1:0] MODE_HEAT = 2'd3;

  // relay codes, bits 7:4 of the mode byte
  localparam logic [3:0] RELAY_STOP = 4'h0;
  localparam logic [3:0] RELAY_FAN  = 4'h1;
  localparam logic [3:0] RELAY_COOL = 4'h7;
  localparam logic [3:0] RELAY_HEAT = 4'h9;

  // motor positions in the fault flags
  localparam int MOTOR_FAN    = 0;
  localparam int MOTOR_INDOOR = 1;
  localparam int MOTOR_COMP   = 2;
  localparam int MOTOR_HEATER = 3;

  localparam logic [5:0] HZ_BASE = 6'd50;

  // register indexes
  localparam logic [2:0] REG_HIT_LIMIT_FAN    = 3'd0;
  localparam logic [2:0] REG_HIT_LIMIT_INDOOR = 3'd1;
  localparam logic [2:0] REG_HIT_LIMIT_COMP   = 3'd2;
  localparam logic [2:0] REG_HIT_LIMIT_HEATER = 3'd3;
  localparam logic [2:0] REG_RECOVERY_TICKS   = 3'd4;
  localparam logic [2:0] REG_FAN_HOLD_TICKS   = 3'd5;
  localparam logic [2:0] REG_SWITCH_FREQ_LIM  = 3'd6;

  localparam logic [7:0]  HIT_LIMIT_RST      = 8'd3;
  localparam logic [14:0] RECOVERY_TICKS_RST = 15'd24000;
  localparam logic [8:0]  FAN_HOLD_TICKS_RST = 9'd500;
  localparam logic [7:0]  SWITCH_FREQ_RST    = 8'd6;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] setting_byte;
    logic [7:0] running_freq;
    logic [1:0] motor_index;
  } hmsl_item_t;

  typedef struct packed {
    logic [MOTOR_COUNT-1:0][7:0] hit_limit;
    logic [14:0]                 recovery_ticks;
    logic [8:0]                  fan_hold_ticks;
    logic [7:0]                  switch_freq_limit;
  } hmsl_cfg_t;

  typedef struct packed {
    logic [7:0]                   mode;
    logic [8:0]                   fan_timer;
    logic                         ramp;
    logic [MOTOR_COUNT-1:0]       fault;
    logic [MOTOR_COUNT-1:0][14:0] rec_cnt;
    logic [MOTOR_COUNT-1:0][7:0]  hit_cnt;
    logic [5:0]                   hold_hz;
    logic [3:0]                   hold_granted;
  } hmsl_state_t;

  typedef struct packed {
    logic [7:0] mode_byte;
    logic [5:0] target_hz;
    logic [8:0] target_tenths;
    logic [3:0] granted_mode;
    logic [3:0] fault_flags;
    logic       ramp_down;
  } hmsl_result_t;

endpackage

`default_nettype wire

// ----- hdl/hmsl_if.sv -----
`default_nettype none

interface hmsl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] setting_byte;
  logic [7:0] running_freq;
  logic [1:0] motor_index;

  modport source (output valid, output op, output setting_byte, output running_freq,
                  output motor_index, input ready);
  modport sink   (input valid, input op, input setting_byte, input running_freq,
                  input motor_index, output ready);
endinterface

interface hmsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mode_byte;
  logic [5:0] target_hz;
  logic [8:0] target_tenths;
  logic [3:0] granted_mode;
  logic [3:0] fault_flags;
  logic       ramp_down;

  modport source (output valid, output mode_byte, output target_hz, output target_tenths,
                  output granted_mode, output fault_flags, output ramp_down, input ready);
  modport sink   (input valid, input mode_byte, input target_hz, input target_tenths,
                  input granted_mode, input fault_flags, input ramp_down, output ready);
endinterface

`default_nettype wire

// ----- hdl/hvac_mode_sequencer_with_lockout.sv -----
`default_nettype none

// Channel   Dir  Handshake          Beat contents
// in_ch     in   valid/ready        op, setting_byte, running_freq, motor_index
// out_ch    out  valid/ready        mode_byte, target_hz, target_tenths,
//                                   granted_mode, fault_flags, ramp_down
// cfg_*     in   APB (pready = 1)   seven registers at byte address 4*i
//
// One beat a cycle sustained while out_ch does not stall. A beat taken into the input
// register is stepped through the single-pass logic into the result register once that
// register is free or being emptied, and its result is then on out_ch.
// rst_n is synchronous: it clears the sequencer state and both pipeline valids and
// loads the register defaults.
// A stalled out_ch holds its beat; in_ch keeps taking beats until both registers
// are full, so a result waiting to be taken does not block the next beat.
module hvac_mode_sequencer_with_lockout (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hmsl_in_if.sink          in_ch,
  hmsl_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  hmsl_pkg::hmsl_cfg_t    cfg_r;
  hmsl_pkg::hmsl_state_t  state_r;
  hmsl_pkg::hmsl_state_t  state_nxt;
  hmsl_pkg::hmsl_item_t   item_r;
  hmsl_pkg::hmsl_result_t res_r;
  hmsl_pkg::hmsl_result_t res_nxt;
  logic                   item_vld_r;
  logic                   out_vld_r;
  logic                   step_go;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  // ---------------------------------------------------------------------------
  // Register port. Writes land on the access cycle; unused addresses are ignored.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_limit         <= {hmsl_pkg::MOTOR_COUNT{hmsl_pkg::HIT_LIMIT_RST}};
      cfg_r.recovery_ticks    <= hmsl_pkg::RECOVERY_TICKS_RST;
      cfg_r.fan_hold_ticks    <= hmsl_pkg::FAN_HOLD_TICKS_RST;
      cfg_r.switch_freq_limit <= hmsl_pkg::SWITCH_FREQ_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hmsl_pkg::REG_HIT_LIMIT_FAN:    cfg_r.hit_limit[hmsl_pkg::MOTOR_FAN] <= cfg_pwdata[7:0];
        hmsl_pkg::REG_HIT_LIMIT_INDOOR:
          cfg_r.hit_limit[hmsl_pkg::MOTOR_INDOOR] <= cfg_pwdata[7:0];
        hmsl_pkg::REG_HIT_LIMIT_COMP:   cfg_r.hit_limit[hmsl_pkg::MOTOR_COMP] <= cfg_pwdata[7:0];
        hmsl_pkg::REG_HIT_LIMIT_HEATER:
          cfg_r.hit_limit[hmsl_pkg::MOTOR_HEATER] <= cfg_pwdata[7:0];
        hmsl_pkg::REG_RECOVERY_TICKS:   cfg_r.recovery_ticks    <= cfg_pwdata[14:0];
        hmsl_pkg::REG_FAN_HOLD_TICKS:   cfg_r.fan_hold_ticks    <= cfg_pwdata[8:0];
        hmsl_pkg::REG_SWITCH_FREQ_LIM:  cfg_r.switch_freq_limit <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hmsl_pkg::REG_HIT_LIMIT_FAN:
        cfg_prdata = {24'd0, cfg_r.hit_limit[hmsl_pkg::MOTOR_FAN]};
      hmsl_pkg::REG_HIT_LIMIT_INDOOR:
        cfg_prdata = {24'd0, cfg_r.hit_limit[hmsl_pkg::MOTOR_INDOOR]};
      hmsl_pkg::REG_HIT_LIMIT_COMP:
        cfg_prdata = {24'd0, cfg_r.hit_limit[hmsl_pkg::MOTOR_COMP]};
      hmsl_pkg::REG_HIT_LIMIT_HEATER:
        cfg_prdata = {24'd0, cfg_r.hit_limit[hmsl_pkg::MOTOR_HEATER]};
      hmsl_pkg::REG_RECOVERY_TICKS:  cfg_prdata = {17'd0, cfg_r.recovery_ticks};
      hmsl_pkg::REG_FAN_HOLD_TICKS:  cfg_prdata = {23'd0, cfg_r.fan_hold_ticks};
      hmsl_pkg::REG_SWITCH_FREQ_LIM: cfg_prdata = {24'd0, cfg_r.switch_freq_limit};
      default:                       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. The held beat steps the sequencer when the result register
  // is free or being emptied; a new beat is taken in that same cycle.
  // ---------------------------------------------------------------------------
  assign step_go     = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.op           <= in_ch.op;
      item_r.setting_byte <= in_ch.setting_byte;
      item_r.running_freq <= in_ch.running_freq;
      item_r.motor_index  <= in_ch.motor_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer step: message, tick or hit, all in one pass.
  // ---------------------------------------------------------------------------
  hmsl_step u_step (
    .item    (item_r),
    .cfg     (cfg_r),
    .st      (state_r),
    .st_nxt  (state_nxt),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register; holds its beat while out_ch stalls.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.mode_byte     = res_r.mode_byte;
  assign out_ch.target_hz     = res_r.target_hz;
  assign out_ch.target_tenths = res_r.target_tenths;
  assign out_ch.granted_mode  = res_r.granted_mode;
  assign out_ch.fault_flags   = res_r.fault_flags;
  assign out_ch.ramp_down     = res_r.ramp_down;

endmodule

`default_nettype wire

// ----- hdl/hmsl_step.sv -----
`default_nettype none

// Next state and result for one beat.
module hmsl_step (
  input  var hmsl_pkg::hmsl_item_t   item,
  input  var hmsl_pkg::hmsl_cfg_t    cfg,
  input  var hmsl_pkg::hmsl_state_t  st,
  output hmsl_pkg::hmsl_state_t      st_nxt,
  output hmsl_pkg::hmsl_result_t     res_nxt
);

  always_comb begin
    logic [1:0] g;
    logic [1:0] tmode_port;
    logic [1:0] cur;
    logic [1:0] low;
    logic [9:0] timer;
    logic [3:0] relay;
    logic       rise;

    st_nxt     = st;
    g          = item.setting_byte[1:0];
    tmode_port = item.setting_byte[3:2];
    cur        = st.mode[1:0];
    low        = cur;
    timer      = '0;
    relay      = hmsl_pkg::RELAY_STOP;
    rise       = 1'b0;

    unique case (item.op)
      hmsl_pkg::OP_SETTING: begin
        st_nxt.hold_hz = hmsl_pkg::HZ_BASE - {2'b00, item.setting_byte[7:4]};

        // lockout limiting
        if (st.fault[hmsl_pkg::MOTOR_FAN]) g = hmsl_pkg::MODE_STOP;
        if ((st.fault[hmsl_pkg::MOTOR_INDOOR] || st.fault[hmsl_pkg::MOTOR_COMP]) &&
            g == hmsl_pkg::MODE_COOL) g = hmsl_pkg::MODE_FAN;
        if (st.fault[hmsl_pkg::MOTOR_HEATER] && g == hmsl_pkg::MODE_HEAT)
          g = hmsl_pkg::MODE_FAN;

        // fan hold
        if (cur == hmsl_pkg::MODE_FAN) timer = {1'b0, st.fan_timer} + 10'd1;
        if (timer > {1'b0, cfg.fan_hold_ticks}) timer = {1'b0, cfg.fan_hold_ticks};
        if (g[1] && !cur[1] && timer < {1'b0, cfg.fan_hold_ticks}) g = hmsl_pkg::MODE_FAN;
        st_nxt.fan_timer = timer[8:0];

        // ramp-down request
        rise = g[1] && !cur[1];
        if (rise) begin
          if (item.running_freq >= cfg.switch_freq_limit) begin
            g = hmsl_pkg::MODE_FAN;
            st_nxt.ramp = 1'b1;
          end
        end else begin
          st_nxt.ramp = 1'b0;
        end

        st_nxt.hold_granted = {tmode_port, g};

        // cool and heat only meet through fan
        unique case (cur)
          hmsl_pkg::MODE_STOP: low = (g != hmsl_pkg::MODE_STOP) ? hmsl_pkg::MODE_FAN
                                                                 : hmsl_pkg::MODE_STOP;
          hmsl_pkg::MODE_FAN:  low = g;
          hmsl_pkg::MODE_COOL: low = (g == hmsl_pkg::MODE_HEAT) ? hmsl_pkg::MODE_FAN : g;
          default:             low = (g == hmsl_pkg::MODE_COOL) ? hmsl_pkg::MODE_FAN : g;
        endcase

        // port change: back to stop, faults and counters cleared
        if (tmode_port != st.mode[3:2]) begin
          low            = hmsl_pkg::MODE_STOP;
          st_nxt.fault   = '0;
          st_nxt.rec_cnt = '0;
          st_nxt.hit_cnt = '0;
        end

        if (low == hmsl_pkg::MODE_STOP) begin
          st_nxt.fan_timer = '0;
          st_nxt.ramp      = 1'b1;
        end

        unique case (low)
          hmsl_pkg::MODE_STOP: relay = hmsl_pkg::RELAY_STOP;
          hmsl_pkg::MODE_FAN:  relay = hmsl_pkg::RELAY_FAN;
          hmsl_pkg::MODE_COOL: relay = hmsl_pkg::RELAY_COOL;
          default:             relay = hmsl_pkg::RELAY_HEAT;
        endcase
        st_nxt.mode = {relay, tmode_port, low};
      end

      hmsl_pkg::OP_TICK: begin
        for (int m = 0; m < hmsl_pkg::MOTOR_COUNT; m++) begin
          if (st.hit_cnt[m] >= cfg.hit_limit[m]) begin
            st_nxt.hit_cnt[m] = '0;
            st_nxt.fault[m]   = 1'b1;
          end
          if (st_nxt.fault[m] && st.rec_cnt[m] != '1)
            st_nxt.rec_cnt[m] = st.rec_cnt[m] + 15'd1;
          if (st_nxt.rec_cnt[m] >= cfg.recovery_ticks) begin
            st_nxt.rec_cnt[m] = '0;
            st_nxt.fault[m]   = 1'b0;
          end
        end
      end

      hmsl_pkg::OP_HIT: begin
        if (st.hit_cnt[item.motor_index] != '1)
          st_nxt.hit_cnt[item.motor_index] = st.hit_cnt[item.motor_index] + 8'd1;
      end

      default: ;
    endcase
  end

  // tenths = hz * 10 as two shifted terms
  assign res_nxt.mode_byte     = st_nxt.mode;
  assign res_nxt.target_hz     = st_nxt.hold_hz;
  assign res_nxt.target_tenths = {st_nxt.hold_hz, 3'b000} + {2'b00, st_nxt.hold_hz, 1'b0};
  assign res_nxt.granted_mode  = st_nxt.hold_granted;
  assign res_nxt.fault_flags   = st_nxt.fault;
  assign res_nxt.ramp_down     = st_nxt.ramp;

endmodule

`default_nettype wire
